[src/utf8_stream_decoder_core_macros.svh]
// assertion macros for the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define U8SD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8 decoder check failed");

// next-cycle implication, disabled during reset
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8 decoder check failed");

`else

`define U8SD_ASSERT_SAME(label, clk, rst, ante, cons)
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/utf8sd_pkg.sv]
// shared types and constants for the utf8 stream decoder
package utf8sd_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int CP_WIDTH   = 21;
   localparam int LEN_WIDTH  = 3;
   localparam int PEND_WIDTH = 2;

   localparam logic [1:0] CONT_TAG = 2'b10;

   typedef struct packed {
      logic [PEND_WIDTH-1:0] pending;
      logic [CP_WIDTH-1:0]   accum;
      logic [LEN_WIDTH-1:0]  length;
   } dec_state_type;

   typedef struct packed {
      logic                 emit;
      logic [CP_WIDTH-1:0]  scalar_value;
      logic [LEN_WIDTH-1:0] unit_length;
   } dec_result_type;

   localparam dec_state_type IDLE_STATE = '{pending: '0, accum: '0, length: '0};

endpackage

[src/utf8_stream_decoder_core.sv]
// utf8 stream decoder top level: input register, decode step, result register
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_data_byte[7:0]
//   rsp      out        rsp_valid/rsp_ready   rsp_scalar_value[20:0], rsp_unit_length[2:0]
//
// one byte per cycle while rsp is not stalled; a taken byte waits in the input register
// until it is decoded, and its result, if any, is visible the cycle after it is decoded
// the decode state update loops from the state register through the step logic
// reset clears the input valid flag, decode state and result valid flag, not the data
// a stalled rsp holds the decoder only when a byte is waiting to be decoded
module utf8_stream_decoder_core
   import utf8sd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_WIDTH-1:0] req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CP_WIDTH-1:0]   rsp_scalar_value,
   output logic [LEN_WIDTH-1:0]  rsp_unit_length
);

`include "utf8_stream_decoder_core_macros.svh"

   logic                  in_valid_ff;
   logic [BYTE_WIDTH-1:0] in_byte_ff;
   dec_state_type         state_ff;
   dec_state_type         state_in;
   dec_result_type        step_result;
   logic                  rsp_valid_ff;
   logic [CP_WIDTH-1:0]   rsp_cp_ff;
   logic [LEN_WIDTH-1:0]  rsp_len_ff;
   logic                  advance;

   utf8sd_step u_step (
      .cur_state  (state_ff),
      .data_byte  (in_byte_ff),
      .next_state (state_in),
      .result     (step_result)
   );

   // decode the held byte when the result register is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_STATE;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step_result.emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_result.emit) begin
         rsp_cp_ff  <= step_result.scalar_value;
         rsp_len_ff <= step_result.unit_length;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scalar_value = rsp_cp_ff;
   assign rsp_unit_length  = rsp_len_ff;

   // idle decode state is always fully cleared
   `U8SD_ASSERT_SAME(a_idle_clear, clock, reset, state_ff.pending == '0,
      state_ff.accum == '0 && state_ff.length == '0)

   // pending unit length plus bytes still expected never exceeds four
   `U8SD_ASSERT_SAME(a_pending_len, clock, reset, state_ff.pending != '0,
      state_ff.length != '0 &&
      ({1'b0, state_ff.length} + {2'b00, state_ff.pending}) <= 4'd4)

   // one-byte results are plain ascii
   `U8SD_ASSERT_SAME(a_ascii_result, clock, reset,
      rsp_valid_ff && rsp_len_ff == LEN_WIDTH'(1),
      rsp_cp_ff < CP_WIDTH'(128))

   // a result always carries a length from one to four
   `U8SD_ASSERT_SAME(a_len_range, clock, reset, rsp_valid_ff,
      rsp_len_ff != '0 && rsp_len_ff <= LEN_WIDTH'(4))

   // an emitted result lands in the result register next cycle
   `U8SD_ASSERT_NEXT(a_emit_lands, clock, reset, advance && step_result.emit,
      rsp_valid_ff)

endmodule

[src/utf8sd_step.sv]
// next-state and result logic for one byte of the utf8 stream
module utf8sd_step
   import utf8sd_pkg::*;
(
   input  dec_state_type          cur_state,
   input  logic [BYTE_WIDTH-1:0]  data_byte,
   output dec_state_type          next_state,
   output dec_result_type         result
);

   logic [CP_WIDTH-1:0]   accum_in;
   logic [LEN_WIDTH-1:0]  length_in;
   logic [PEND_WIDTH-1:0] pending_in;

   assign accum_in   = {cur_state.accum[CP_WIDTH-7:0], data_byte[5:0]};
   assign length_in  = cur_state.length + LEN_WIDTH'(1);
   assign pending_in = cur_state.pending - PEND_WIDTH'(1);

   always_comb begin
      next_state = cur_state;
      result     = '0;
      if (cur_state.pending == '0) begin
         case (data_byte) inside
            [8'h00:8'h7F]: begin
               result.emit         = 1'b1;
               result.scalar_value = CP_WIDTH'(data_byte[6:0]);
               result.unit_length  = LEN_WIDTH'(1);
            end
            [8'hC0:8'hDF]: begin
               next_state.pending = PEND_WIDTH'(1);
               next_state.accum   = CP_WIDTH'(data_byte[4:0]);
               next_state.length  = LEN_WIDTH'(1);
            end
            [8'hE0:8'hEF]: begin
               next_state.pending = PEND_WIDTH'(2);
               next_state.accum   = CP_WIDTH'(data_byte[3:0]);
               next_state.length  = LEN_WIDTH'(1);
            end
            [8'hF0:8'hF7]: begin
               next_state.pending = PEND_WIDTH'(3);
               next_state.accum   = CP_WIDTH'(data_byte[2:0]);
               next_state.length  = LEN_WIDTH'(1);
            end
            default: begin
               next_state = IDLE_STATE;
            end
         endcase
      end else if (data_byte[7:6] != CONT_TAG) begin
         // interrupted unit: abandon and drop the byte
         next_state = IDLE_STATE;
      end else if (pending_in == '0) begin
         result.emit         = 1'b1;
         result.scalar_value = accum_in;
         result.unit_length  = length_in;
         next_state          = IDLE_STATE;
      end else begin
         next_state.pending = pending_in;
         next_state.accum   = accum_in;
         next_state.length  = length_in;
      end
   end

endmodule
